### design/gmig_pkg.sv
// ----------------------------------------------------------------------------
// gmig_pkg
// Shared types, constants and helpers for the grid mesh index generator.
// ----------------------------------------------------------------------------
package gmig_pkg;

    localparam int MAX_WIDTH  = 254;
    localparam int MAX_HEIGHT = 254;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 16;
    localparam int CORNER_W  = 3;
    localparam int COL_W     = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);

    localparam logic [CORNER_W-1:0] CORNER_LAST_TRI  = CORNER_W'(5);
    localparam logic [CORNER_W-1:0] CORNER_LAST_LINE = CORNER_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_TRI   = 2'd0,
        PH_HLINE = 2'd1,
        PH_VLINE = 2'd2
    } phase_t;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic restart;
        logic mesh_kind;
    } req_t;

    typedef struct packed {
        logic [15:0]         vertex_index;
        logic [CORNER_W-1:0] corner;
        logic                last_of_group;
        logic                last_of_mesh;
    } res_t;

    typedef struct packed {
        phase_t kind;
        idx_t   top;
        idx_t   bot;
        logic   last_mesh;
    } grp_t;

    function automatic col_t eff_width(logic [CFG_W-1:0] v);
        col_t r;
        if (v == '0)
            r = col_t'(1);
        else if (int'(v) > MAX_WIDTH)
            r = col_t'(MAX_WIDTH);
        else
            r = col_t'(v);
        return r;
    endfunction

    function automatic row_t eff_height(logic [CFG_W-1:0] v);
        row_t r;
        if (v == '0)
            r = row_t'(1);
        else if (int'(v) > MAX_HEIGHT)
            r = row_t'(MAX_HEIGHT);
        else
            r = row_t'(v);
        return r;
    endfunction

endpackage

### design/gmig_walker.sv
// ----------------------------------------------------------------------------
// gmig_walker
// Grid size registers and walk state; turns each request into one group
// descriptor (top and bottom corner indices) held in a group register.
// ----------------------------------------------------------------------------
module gmig_walker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gmig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmig_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  gmig_pkg::req_t                   req_data,
    output logic                             grp_valid,
    output gmig_pkg::grp_t                   grp_data,
    input  logic                             grp_pop
);
    import gmig_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    phase_t           phase_reg, phase_next;
    col_t             col_reg, col_next;
    row_t             row_reg, row_next;
    idx_t             base_reg, base_next;
    logic             grp_valid_reg;
    grp_t             grp_reg, grp_next;

    col_t             w_eff;
    row_t             h_eff;
    idx_t             v;
    phase_t           ph_s;
    col_t             col_s;
    row_t             row_s;
    idx_t             base_s;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             accept;

    assign w_eff     = eff_width(width_reg);
    assign h_eff     = eff_height(height_reg);
    assign req_ready = (!grp_valid_reg || grp_pop) && !cfg_we;
    assign accept    = req_valid && req_ready;
    assign grp_valid = grp_valid_reg;
    assign grp_data  = grp_reg;

    always_comb
    begin
        ph_s   = phase_reg;
        col_s  = col_reg;
        row_s  = row_reg;
        base_s = base_reg;
        if (req_data.restart)
        begin
            ph_s   = req_data.mesh_kind ? PH_HLINE : PH_TRI;
            col_s  = '0;
            row_s  = '0;
            base_s = '0;
        end

        v       = idx_t'(w_eff) + idx_t'(2);
        col_inc = (COL_W+1)'(col_s) + (COL_W+1)'(1);
        row_inc = (ROW_W+1)'(row_s) + (ROW_W+1)'(1);

        grp_next.kind      = ph_s;
        grp_next.top       = base_s + idx_t'(col_s);
        grp_next.bot       = base_s + idx_t'(col_s) + v;
        grp_next.last_mesh = 1'b0;

        phase_next = ph_s;
        col_next   = col_s;
        row_next   = row_s;
        base_next  = base_s;

        unique case (ph_s)
            PH_HLINE:
            begin
                if (col_inc >= (COL_W+1)'(w_eff) + (COL_W+1)'(1))
                begin
                    col_next  = '0;
                    row_next  = row_inc[ROW_W-1:0];
                    base_next = base_s + v;
                    if (row_inc >= (ROW_W+1)'(h_eff) + (ROW_W+1)'(2))
                    begin
                        phase_next = PH_VLINE;
                        row_next   = '0;
                        base_next  = '0;
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            PH_VLINE:
            begin
                row_next  = row_inc[ROW_W-1:0];
                base_next = base_s + v;
                if (row_inc >= (ROW_W+1)'(h_eff) + (ROW_W+1)'(1))
                begin
                    row_next  = '0;
                    base_next = '0;
                    if (col_inc >= (COL_W+1)'(w_eff) + (COL_W+1)'(2))
                    begin
                        grp_next.last_mesh = 1'b1;
                        phase_next         = PH_HLINE;
                        col_next           = '0;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end
            end
            default:
            begin
                grp_next.kind = PH_TRI;
                phase_next    = PH_TRI;
                if (col_inc >= (COL_W+1)'(w_eff) + (COL_W+1)'(1))
                begin
                    col_next  = '0;
                    row_next  = row_inc[ROW_W-1:0];
                    base_next = base_s + v;
                    if (row_inc >= (ROW_W+1)'(h_eff) + (ROW_W+1)'(1))
                    begin
                        grp_next.last_mesh = 1'b1;
                        row_next           = '0;
                        base_next          = '0;
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_W'(1);
            height_reg    <= CFG_W'(1);
            phase_reg     <= PH_TRI;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:  width_reg  <= cfg_data;
                    REG_GRID_HEIGHT: height_reg <= cfg_data;
                    default:         width_reg  <= cfg_data;
                endcase
                phase_reg <= (phase_reg == PH_HLINE || phase_reg == PH_VLINE) ? PH_HLINE : PH_TRI;
                col_reg   <= '0;
                row_reg   <= '0;
                base_reg  <= '0;
            end
            else if (accept)
            begin
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                base_reg  <= base_next;
            end
            if (accept)
                grp_valid_reg <= 1'b1;
            else if (grp_pop)
                grp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            grp_reg <= grp_next;
    end

endmodule

### design/gmig_emitter.sv
// ----------------------------------------------------------------------------
// gmig_emitter
// Steps through the corners of the held group, one vertex index per cycle
// while the receiver takes each result, into the result register.
// ----------------------------------------------------------------------------
module gmig_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           grp_valid,
    input  gmig_pkg::grp_t grp_data,
    output logic           grp_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output gmig_pkg::res_t res_data
);
    import gmig_pkg::*;

    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic                res_valid_reg;
    res_t                res_reg, res_next;
    logic                load;
    logic                use_bot;
    logic                plus_one;
    logic                is_last;
    logic [CORNER_W-1:0] corner_last;

    assign load        = grp_valid && (!res_valid_reg || res_ready);
    assign corner_last = (grp_data.kind == PH_TRI) ? CORNER_LAST_TRI : CORNER_LAST_LINE;
    assign is_last     = (corner_reg == corner_last);
    assign grp_pop     = load && is_last;
    assign corner_next = is_last ? '0 : corner_reg + CORNER_W'(1);
    assign res_valid   = res_valid_reg;
    assign res_data    = res_reg;

    always_comb
    begin
        use_bot  = 1'b0;
        plus_one = 1'b0;
        unique case (grp_data.kind)
            PH_HLINE:
            begin
                plus_one = corner_reg[0];
            end
            PH_VLINE:
            begin
                use_bot = corner_reg[0];
            end
            default:
            begin
                unique case (corner_reg)
                    CORNER_W'(1), CORNER_W'(4): plus_one = 1'b1;
                    CORNER_W'(2), CORNER_W'(3): use_bot  = 1'b1;
                    CORNER_W'(5):
                    begin
                        use_bot  = 1'b1;
                        plus_one = 1'b1;
                    end
                    default:                    use_bot  = 1'b0;
                endcase
            end
        endcase

        res_next.vertex_index  = 16'((use_bot ? grp_data.bot : grp_data.top)
                                     + idx_t'(plus_one));
        res_next.corner        = corner_reg;
        res_next.last_of_group = is_last;
        res_next.last_of_mesh  = is_last && grp_data.last_mesh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            corner_reg    <= corner_next;
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

endmodule

### design/grid_mesh_index_generator_top.sv
// ----------------------------------------------------------------------------
// grid_mesh_index_generator_top
// Emits triangle-list or line-list vertex indices for a regular vertex grid.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_data write grid_width (index 0) or grid_height
//   (index 1); any write restarts the walk at the first item of the current
//   mesh kind. Write only while no request is in flight.
//   Each request on req_valid/req_ready advances the walk by one cell
//   (triangle mode, six indices) or one segment (line mode, two indices);
//   restart=1 selects mesh_kind and begins at the first item.
//   Results leave on res_valid/res_ready, one index per cycle while res_ready
//   is high. The first index of a request passes through the group register
//   and then the result register; the single-index result register emits a
//   request's indices one at a time. The next request is taken in the cycle its
//   predecessor's last index is loaded, so groups follow without gaps.
//   A stalled receiver holds the result register and the group register;
//   requests then wait.
//   Reset: grid 1 x 1, walk at the first triangle cell, no result pending.
// ----------------------------------------------------------------------------
module grid_mesh_index_generator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gmig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmig_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  gmig_pkg::req_t                   req_data,
    output logic                             res_valid,
    input  logic                             res_ready,
    output gmig_pkg::res_t                   res_data
);
    import gmig_pkg::*;

    logic grp_valid;
    grp_t grp_data;
    logic grp_pop;

    gmig_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .grp_valid (grp_valid),
        .grp_data  (grp_data),
        .grp_pop   (grp_pop)
    );

    gmig_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_data  (grp_data),
        .grp_pop   (grp_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

`ifndef NO_ASSERTIONS
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |=> res_valid && res_data.last_of_group)
        else $error("group released without last index");

    a_mesh_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.last_of_mesh |-> res_data.last_of_group)
        else $error("end of mesh outside group end");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.corner <= CORNER_LAST_TRI)
        else $error("corner out of range");
`endif

endmodule
